### rtl/vector_heading_angle_top_defines.svh
// assertion macros for the heading block checker
`ifndef VECTOR_HEADING_ANGLE_TOP_DEFINES_SVH
`define VECTOR_HEADING_ANGLE_TOP_DEFINES_SVH

// sampling clock for every check
`define VHA_CLK @(posedge clock)

// check that is held off while reset is high
`define VHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (`VHA_CLK disable iff (reset) prop) else $error(msg);

`endif

### rtl/vha_pkg.sv
package vha_pkg;

   localparam int COORD_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int STAGES     = 16;

   localparam int TURN_BITS      = 32;
   localparam int ATAN_ENTRIES   = 24;
   localparam int ATAN_IDX_BITS  = 5;
   localparam int STAGE_IDX_BITS = (STAGES > 1) ? $clog2(STAGES) : 1;

   // fraction bits kept below the pixel through every micro-rotation
   localparam int GUARD_SHIFT = 60 - COORD_BITS;

   // difference, negation and fold need coord+2 bits, gain and growth need two more
   localparam int VEC_BITS = COORD_BITS + GUARD_SHIFT + 4;

   localparam logic [TURN_BITS-1:0] HALF_TURN_Z = TURN_BITS'(1) << (TURN_BITS - 1);
   localparam logic [TURN_BITS-1:0] ROUND_BIAS  =
      TURN_BITS'(1) << (TURN_BITS - ANGLE_BITS - 1);

   localparam logic [ANGLE_BITS-1:0] HEADING_UP      = '0;
   localparam logic [ANGLE_BITS-1:0] HEADING_RIGHT   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] HEADING_DOWN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic [ANGLE_BITS-1:0] HEADING_LEFT    = HEADING_DOWN | HEADING_RIGHT;

   // atan(2^-i) as a fraction of one turn, 32-bit, rounded to nearest
   localparam logic [TURN_BITS-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic signed [VEC_BITS-1:0]   u;
      logic signed [VEC_BITS-1:0]   v;
      logic [TURN_BITS-1:0]         z;
      logic                         axis;
      logic [ANGLE_BITS-1:0]        axis_heading;
   } vec_type;

   function automatic logic [TURN_BITS-1:0] atan_turn(input logic [STAGE_IDX_BITS-1:0] idx);
      atan_turn = ATAN_TURNS[ATAN_IDX_BITS'(idx)];
   endfunction

endpackage

### rtl/vector_heading_angle_top.sv
// heading of the vector from an origin point to a target point, clockwise from up
//
// request channel: req_valid/req_ready with req_target_x/y and req_origin_x/y,
// signed pixel coordinates with y growing downward
// response channel: rsp_valid/rsp_ready with rsp_heading, an unsigned binary
// angle in 1/65536 of a turn, wrapping at one full turn
// one response per request transaction, in request order
// path: a request goes from the accepting edge to rsp_valid through the input
// register, one register per cordic micro-rotation and the rounding register,
// STAGES + 2 registers in all
// throughput: one transaction per clock while rsp_ready is high
// a stalled rsp_ready holds the output; earlier stages keep filling empty slots
// and req_ready drops only once every stage holds a transaction
// reset empties the pipeline; the block keeps no other state
module vector_heading_angle_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vha_pkg::ANGLE_BITS-1:0]        rsp_heading
);

   vha_pkg::vec_type stage_data  [vha_pkg::STAGES+1];
   logic             stage_valid [vha_pkg::STAGES+1];
   logic             stage_ready [vha_pkg::STAGES+1];

   vha_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .out_ready    (stage_ready[0]),
      .out_valid    (stage_valid[0]),
      .out_data     (stage_data[0])
   );

   for (genvar k = 0; k < vha_pkg::STAGES; k++) begin : g_stage
      vha_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (vha_pkg::STAGE_IDX_BITS'(k)),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_ready (stage_ready[k+1]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   vha_round u_round (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid[vha_pkg::STAGES]),
      .in_ready    (stage_ready[vha_pkg::STAGES]),
      .in_data     (stage_data[vha_pkg::STAGES]),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_heading (rsp_heading)
   );

endmodule

### rtl/vha_prep.sv
module vha_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_y,
   input  logic                                  out_ready,
   output logic                                  out_valid,
   output vha_pkg::vec_type                      out_data
);

   logic                                  valid_ff;
   vha_pkg::vec_type                      data_ff;
   vha_pkg::vec_type                      data_in;
   logic signed [vha_pkg::COORD_BITS:0]   dx;
   logic signed [vha_pkg::COORD_BITS:0]   dy;
   logic signed [vha_pkg::COORD_BITS+1:0] up;
   logic signed [vha_pkg::COORD_BITS+1:0] u_f;
   logic signed [vha_pkg::COORD_BITS+1:0] v_f;
   logic                                  dx_zero;
   logic                                  dy_zero;

   assign dx = (vha_pkg::COORD_BITS+1)'(req_target_x) - (vha_pkg::COORD_BITS+1)'(req_origin_x);
   assign dy = (vha_pkg::COORD_BITS+1)'(req_target_y) - (vha_pkg::COORD_BITS+1)'(req_origin_y);
   assign up = -((vha_pkg::COORD_BITS+2)'(dy));
   assign dx_zero = (dx == '0);
   assign dy_zero = (dy == '0);

   always_comb begin
      data_in = '0;
      // fold into the upper half plane by a half turn
      if (up[vha_pkg::COORD_BITS+1]) begin
         u_f       = -up;
         v_f       = -((vha_pkg::COORD_BITS+2)'(dx));
         data_in.z = vha_pkg::HALF_TURN_Z;
      end else begin
         u_f       = up;
         v_f       = (vha_pkg::COORD_BITS+2)'(dx);
         data_in.z = '0;
      end
      data_in.u = vha_pkg::VEC_BITS'(u_f) <<< vha_pkg::GUARD_SHIFT;
      data_in.v = vha_pkg::VEC_BITS'(v_f) <<< vha_pkg::GUARD_SHIFT;
      data_in.axis = dx_zero || dy_zero;
      if (dx_zero && dy_zero) begin
         data_in.axis_heading = vha_pkg::HEADING_RIGHT;
      end else if (dx_zero && dy[vha_pkg::COORD_BITS]) begin
         data_in.axis_heading = vha_pkg::HEADING_UP;
      end else if (dx_zero) begin
         data_in.axis_heading = vha_pkg::HEADING_DOWN;
      end else if (!dx[vha_pkg::COORD_BITS]) begin
         data_in.axis_heading = vha_pkg::HEADING_RIGHT;
      end else begin
         data_in.axis_heading = vha_pkg::HEADING_LEFT;
      end
   end

   assign req_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/vha_stage.sv
module vha_stage (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [vha_pkg::STAGE_IDX_BITS-1:0]        stage_idx,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  vha_pkg::vec_type                          in_data,
   input  logic                                      out_ready,
   output logic                                      out_valid,
   output vha_pkg::vec_type                          out_data
);

   logic                               valid_ff;
   vha_pkg::vec_type                   data_ff;
   vha_pkg::vec_type                   data_in;
   logic signed [vha_pkg::VEC_BITS-1:0] su;
   logic signed [vha_pkg::VEC_BITS-1:0] sv;
   logic [vha_pkg::TURN_BITS-1:0]       step;
   logic                                v_pos;

   assign su    = in_data.u >>> stage_idx;
   assign sv    = in_data.v >>> stage_idx;
   assign step  = vha_pkg::atan_turn(stage_idx);
   assign v_pos = !in_data.v[vha_pkg::VEC_BITS-1] && (in_data.v != '0);

   always_comb begin
      data_in = in_data;
      // micro-rotation toward the up axis
      if (v_pos) begin
         data_in.u = in_data.u + sv;
         data_in.v = in_data.v - su;
         data_in.z = in_data.z + step;
      end else begin
         data_in.u = in_data.u - sv;
         data_in.v = in_data.v + su;
         data_in.z = in_data.z - step;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/vha_round.sv
module vha_round (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  vha_pkg::vec_type                    in_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [vha_pkg::ANGLE_BITS-1:0]      rsp_heading
);

   logic                              valid_ff;
   logic [vha_pkg::ANGLE_BITS-1:0]    heading_ff;
   logic [vha_pkg::ANGLE_BITS-1:0]    heading_in;
   logic [vha_pkg::TURN_BITS-1:0]     z_r;

   // round half up, wraps modulo one turn
   assign z_r = in_data.z + vha_pkg::ROUND_BIAS;
   assign heading_in = in_data.axis ? in_data.axis_heading
                                    : z_r[vha_pkg::TURN_BITS-1 -: vha_pkg::ANGLE_BITS];

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_heading = heading_ff;

endmodule

### rtl/vha_checker.sv
`include "vector_heading_angle_top_defines.svh"

module vha_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [vha_pkg::ANGLE_BITS-1:0]   rsp_heading
);

   `VHA_ASSERT(a_empty_after_reset, $past(reset) |-> !rsp_valid, "response valid right after reset")
   `VHA_ASSERT(a_ready_when_drained, rsp_ready |-> req_ready, "request stalled while output drains")
   `VHA_ASSERT(a_ready_when_empty_out, !rsp_valid |-> req_ready, "request stalled with empty output")
   `VHA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading), "stalled response changed")

endmodule

bind vector_heading_angle_top vha_checker u_vha_checker (.*);

### bench/vector_heading_angle_checker.sv
module vector_heading_angle_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_x,
   input  logic signed [vha_pkg::COORD_BITS-1:0] req_origin_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [vha_pkg::ANGLE_BITS-1:0]        rsp_heading,
   output int                                    errors,
   output int                                    outstanding,
   output int                                    checked
);

   localparam int CB           = vha_pkg::COORD_BITS;
   localparam int AB           = vha_pkg::ANGLE_BITS;
   localparam int ROTATIONS    = vha_pkg::STAGES;
   localparam int FRAC_BITS    = 32;
   localparam int FRAC_ENTRIES = 24;
   localparam int GUARD        = 60 - CB;
   localparam int REPORT_LIMIT = 10;

   localparam logic [FRAC_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [FRAC_BITS-1:0] HALF_TURN    = 32'h8000_0000;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [FRAC_BITS-1:0] ARC_FRAC [FRAC_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   logic [AB-1:0] expected_headings [$];

   function automatic logic [AB-1:0] rounded_heading(input logic [FRAC_BITS-1:0] z);
      logic [FRAC_BITS-1:0] r;
      r = z + (FRAC_BITS'(1) << (FRAC_BITS - AB - 1));
      return r[FRAC_BITS-1 -: AB];
   endfunction

   function automatic logic [AB-1:0] heading_of(input logic signed [CB-1:0] tx,
                                                input logic signed [CB-1:0] ty,
                                                input logic signed [CB-1:0] ox,
                                                input logic signed [CB-1:0] oy);
      longint               dx;
      longint               dy;
      longint               u;
      longint               v;
      longint               su;
      longint               sv;
      logic [FRAC_BITS-1:0] z;
      int                   i;
      dx = longint'(tx) - longint'(ox);
      dy = longint'(ty) - longint'(oy);
      if (dx == 0 && dy == 0) return rounded_heading(QUARTER_TURN);
      if (dx == 0 && dy < 0) return '0;
      if (dx == 0) return rounded_heading(HALF_TURN);
      if (dy == 0) return rounded_heading((dx > 0) ? QUARTER_TURN : HALF_TURN + QUARTER_TURN);
      // up axis is -dy, right axis is dx; fold into the upper half first
      u = -dy;
      v = dx;
      z = '0;
      if (u < 0) begin
         u = -u;
         v = -v;
         z = HALF_TURN;
      end
      u = u <<< GUARD;
      v = v <<< GUARD;
      for (i = 0; i < ROTATIONS && i < FRAC_ENTRIES; i++) begin
         su = u >>> i;
         sv = v >>> i;
         if (v > 0) begin
            u = u + sv;
            v = v - su;
            z = z + ARC_FRAC[i];
         end else begin
            u = u - sv;
            v = v + su;
            z = z - ARC_FRAC[i];
         end
      end
      return rounded_heading(z);
   endfunction

   always @(posedge clock) begin : track
      logic [AB-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_headings.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected response transaction: heading %0d", rsp_heading);
               errors <= errors + 1;
            end else begin
               want = expected_headings.pop_front();
               checked <= checked + 1;
               if (rsp_heading !== want) begin
                  if (errors < REPORT_LIMIT)
                     $display("heading mismatch at response %0d: expected %0d, got %0d",
                              checked, want, rsp_heading);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready)
            expected_headings.push_back(heading_of(req_target_x, req_target_y,
                                                   req_origin_x, req_origin_y));
         outstanding <= expected_headings.size();
      end
   end

endmodule

### bench/vector_heading_angle_top_tb.sv
module vector_heading_angle_top_tb;

   localparam int CB              = vha_pkg::COORD_BITS;
   localparam int AB              = vha_pkg::ANGLE_BITS;
   localparam int LATENCY         = vha_pkg::STAGES + 2;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int N_DIRECTED      = 23;
   localparam int RANDOM_PER_MIX  = 170;

   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [CB-1:0] req_target_x;
   logic signed [CB-1:0] req_target_y;
   logic signed [CB-1:0] req_origin_x;
   logic signed [CB-1:0] req_origin_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [AB-1:0]        rsp_heading;

   int errors;
   int outstanding;
   int checked;
   int send_idle_pct;
   int recv_idle_pct;
   int n_sent;
   logic hold_rsp;

   vector_heading_angle_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_heading  (rsp_heading)
   );

   vector_heading_angle_checker u_chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_heading  (rsp_heading),
      .errors       (errors),
      .outstanding  (outstanding),
      .checked      (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d transactions still outstanding", outstanding);
      $display("** vector_heading_angle_top: FAILED **");
      $finish;
   end

   // response side: random back-pressure, plus one long hold on request
   initial begin : rsp_side
      logic hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic signed [CB-1:0] tx, input logic signed [CB-1:0] ty,
                            input logic signed [CB-1:0] ox, input logic signed [CB-1:0] oy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid    = 1'b0;
         req_target_x = CB'($urandom);
         req_target_y = CB'($urandom);
         req_origin_x = CB'($urandom);
         req_origin_y = CB'($urandom);
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_target_x = tx;
      req_target_y = ty;
      req_origin_x = ox;
      req_origin_y = oy;
      do @(posedge clock); while (!req_ready);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic signed [CB-1:0] c [4];
      int kind;
      kind = $urandom_range(9);
      for (int k = 0; k < 4; k++)
         c[k] = CB'($urandom);
      case (kind)
         6: c[0] = c[2];
         7: c[1] = c[3];
         8: begin
            c[0] = c[2] + CB'($urandom_range(8)) - CB'(4);
            c[1] = c[3] + CB'($urandom_range(8)) - CB'(4);
         end
         9: begin
            for (int k = 0; k < 4; k++) begin
               case ($urandom_range(4))
                  0: c[k] = CMIN;
                  1: c[k] = '1;
                  2: c[k] = '0;
                  3: c[k] = CB'(1);
                  default: c[k] = CMAX;
               endcase
            end
         end
         default: ;
      endcase
      send_item(c[0], c[1], c[2], c[3]);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_target_x  = '0;
      req_target_y  = '0;
      req_origin_x  = '0;
      req_origin_y  = '0;
      hold_rsp      = 1'b0;
      n_sent        = 0;
      send_idle_pct = 16;
      recv_idle_pct = 62;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero vectors, the four axes, diagonals, full-scale spans and the wrap near up
      send_item(0, 0, 0, 0);
      send_item(5, 5, 5, 5);
      send_item(CMIN, CMIN, CMIN, CMIN);
      send_item(0, -1, 0, 0);
      send_item(0, CMIN, 0, CMAX);
      send_item(0, 1, 0, 0);
      send_item(CMAX, CMAX, CMAX, CMIN);
      send_item(1, 0, 0, 0);
      send_item(CMAX, 0, CMIN, 0);
      send_item(-1, 0, 0, 0);
      send_item(CMIN, 7, CMAX, 7);
      send_item(10, -10, 0, 0);
      send_item(10, 10, 0, 0);
      send_item(-10, 10, 0, 0);
      send_item(-10, -10, 0, 0);
      send_item(-1, CMIN, 0, CMAX);
      send_item(1, CMIN, 0, CMAX);
      send_item(CMAX, CMAX, CMIN, CMIN);
      send_item(CMIN, CMIN, CMAX, CMAX);
      send_item(CMAX, CMIN, CMIN, CMAX);
      send_item(CMIN, CMAX, CMAX, CMIN);
      send_item(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
      send_item(16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA);
      wait_drained();

      repeat (RANDOM_PER_MIX) send_random();
      wait_drained();

      send_idle_pct = 62;
      recv_idle_pct = 16;
      repeat (RANDOM_PER_MIX) send_random();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < RANDOM_PER_MIX; n++) begin
         if (n == 30) hold_rsp = 1'b1;
         send_random();
      end
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);

      $display("covered %0d request transactions: %0d directed axis, diagonal, extreme and",
               n_sent, N_DIRECTED);
      $display("wrap cases, random vectors under three idle mixes and a long output stall;"
               , " %0d responses checked", checked);
      if (errors == 0 && outstanding == 0) begin
         $display("** vector_heading_angle_top: PASSED **");
      end else begin
         $display("%0d mismatches", errors);
         $display("** vector_heading_angle_top: FAILED **");
      end
      $finish;
   end

endmodule

### vector_heading_angle_top.f
+incdir+rtl
rtl/vha_pkg.sv
rtl/vha_prep.sv
rtl/vha_stage.sv
rtl/vha_round.sv
rtl/vector_heading_angle_top.sv
rtl/vha_checker.sv
bench/vector_heading_angle_checker.sv
bench/vector_heading_angle_top_tb.sv
